// File: hdl/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg - schedule matcher shared definitions
// Entry layout in the table memory, command and mask-select codes, defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

    localparam int CSM_ENTRIES = 32;

    // Field widths of one schedule entry
    localparam int MINUTE_W  = 60;
    localparam int HOUR_W    = 24;
    localparam int DOM_W     = 31;
    localparam int MONTH_W   = 12;
    localparam int WEEKDAY_W = 7;
    localparam int STAR_W    = 2;

    // Packed entry layout, minute mask in the low bits
    localparam int MIN_LSB   = 0;
    localparam int HOUR_LSB  = MIN_LSB + MINUTE_W;
    localparam int DOM_LSB   = HOUR_LSB + HOUR_W;
    localparam int MON_LSB   = DOM_LSB + DOM_W;
    localparam int DOW_LSB   = MON_LSB + MONTH_W;
    localparam int STAR_LSB  = DOW_LSB + WEEKDAY_W;
    localparam int ENTRY_W   = STAR_LSB + STAR_W;

    localparam int VALUE_W   = 60;
    localparam int RES_IDX_W = 5;
    localparam int COUNT_W   = 6;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Mask select codes
    localparam logic [2:0] SEL_MINUTE  = 3'd0;
    localparam logic [2:0] SEL_HOUR    = 3'd1;
    localparam logic [2:0] SEL_DOM     = 3'd2;
    localparam logic [2:0] SEL_MONTH   = 3'd3;
    localparam logic [2:0] SEL_WEEKDAY = 3'd4;
    localparam logic [2:0] SEL_STAR    = 3'd5;

    typedef logic [ENTRY_W-1:0] entry_t;

endpackage

`default_nettype wire

// File: hdl/csm_if.sv
// ----------------------------------------------------------------------------
// csm_if - schedule matcher channels
// Command channel (writes and ticks) and result channel, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csm_cmd_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [4:0]  entry_index;
    logic [2:0]  mask_select;
    logic [59:0] mask_value;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [2:0]  day_of_week;

    modport source (
        output valid, command, entry_index, mask_select, mask_value,
               minute, hour, day_of_month, month, day_of_week,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, mask_select, mask_value,
               minute, hour, day_of_month, month, day_of_week,
        output ready
    );
endinterface

interface csm_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] matched_index;
    logic       found;
    logic       last;

    modport source (output valid, matched_index, found, last, input ready);
    modport sink   (input valid, matched_index, found, last, output ready);
endinterface

`default_nettype wire

// File: hdl/csm_ram.sv
// ----------------------------------------------------------------------------
// csm_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/cron_schedule_match.sv
// ----------------------------------------------------------------------------
// cron_schedule_match - schedule table matcher
// Holds schedule entries in one table memory and reports every entry that
// is due at the time carried by a tick.
// ----------------------------------------------------------------------------
//
//  channel   direction  transfer                     payload
//  -------   ---------  ---------------------------  ---------------------------
//  cmd       in         cmd.valid && cmd.ready       write (index, select, value)
//                                                    or tick (calendar time)
//  res       out        res.valid && res.ready       matched_index, found, last
//  cfg       in         cfg_write (no handshake)     entry_count
//
//  A write runs as transfer, read of the entry, merge and write back.
//  A tick reads each entry once through the single read port, entry_count
//  capped at ENTRIES; a hit that meets a held hit and a full output register
//  stalls the scan, and the closing result waits for that register to free.
//  A result held in the output register does not block the next command.
//  No clearing pass after reset: entries are undefined until written.
//  Reset clears entry_count and all control state.
// ----------------------------------------------------------------------------
`default_nettype none

module cron_schedule_match #(
    parameter int ENTRIES = csm_pkg::CSM_ENTRIES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [csm_pkg::COUNT_W-1:0]  cfg_data,
    csm_cmd_if.sink                           cmd,
    csm_res_if.source                         res
);

    import csm_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WRD  = 2'd1;
    localparam logic [1:0] ST_WWR  = 2'd2;
    localparam logic [1:0] ST_SCAN = 2'd3;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CNT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic               eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               out_valid_reg;
    logic [RES_IDX_W-1:0] out_index_reg;
    logic               out_found_reg;
    logic               out_last_reg;

    // Write command operands
    logic [IDX_W-1:0]   wr_addr_reg;
    logic [2:0]         wr_sel_reg;
    logic [VALUE_W-1:0] wr_val_reg;

    // Tick time, decoded to one-hot positions (all zero when out of range)
    logic [MINUTE_W-1:0]  min_hot_reg;
    logic [HOUR_W-1:0]    hour_hot_reg;
    logic [DOM_W-1:0]     dom_hot_reg;
    logic [MONTH_W-1:0]   mon_hot_reg;
    logic [WEEKDAY_W-1:0] dow_hot_reg;

    // ------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------
    logic             cmd_xfer;
    logic             out_free;
    logic             idx_ok;
    logic             sel_ok;
    logic [IDX_W+4:0] cmd_idx_ext;
    logic [CNT_W-1:0] limit_calc;
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;
    logic             entry_hit;
    logic             hit;
    logic             stall;
    logic             push;
    logic [IDX_W-1:0] push_idx;
    logic             push_found;
    logic             push_last;
    logic [IDX_W+4:0] push_idx_ext;
    logic             dom_ok, dow_ok, day_ok;

    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || res.ready;

    // Writes beyond the table or to an unused select code are dropped
    assign cmd_idx_ext = {{IDX_W{1'b0}}, cmd.entry_index};
    assign idx_ok      = (int'(cmd.entry_index) < ENTRIES);
    assign sel_ok      = (cmd.mask_select inside {[SEL_MINUTE:SEL_STAR]});

    // Scan length is entry_count, capped at the table depth
    assign limit_calc = (int'(entry_count_reg) > ENTRIES) ? CNT_W'(ENTRIES)
                                                          : CNT_W'(entry_count_reg);

    // ------------------------------------------------------------------
    // Table memory: one packed entry per address
    // ------------------------------------------------------------------
    csm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Merge the written field into the entry just read back
    always_comb
    begin
        ram_wdata = ram_rdata;
        case (wr_sel_reg)
            SEL_MINUTE:  ram_wdata[MIN_LSB  +: MINUTE_W]  = wr_val_reg[MINUTE_W-1:0];
            SEL_HOUR:    ram_wdata[HOUR_LSB +: HOUR_W]    = wr_val_reg[HOUR_W-1:0];
            SEL_DOM:     ram_wdata[DOM_LSB  +: DOM_W]     = wr_val_reg[DOM_W-1:0];
            SEL_MONTH:   ram_wdata[MON_LSB  +: MONTH_W]   = wr_val_reg[MONTH_W-1:0];
            SEL_WEEKDAY: ram_wdata[DOW_LSB  +: WEEKDAY_W] = wr_val_reg[WEEKDAY_W-1:0];
            SEL_STAR:    ram_wdata[STAR_LSB +: STAR_W]    = wr_val_reg[STAR_W-1:0];
            default:     ram_wdata = ram_rdata;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry check: minute, hour and month must hit; the day test is
    // both day fields when either star flag is set, else either one
    // ------------------------------------------------------------------
    assign dom_ok = |(ram_rdata[DOM_LSB +: DOM_W] & dom_hot_reg);
    assign dow_ok = |(ram_rdata[DOW_LSB +: WEEKDAY_W] & dow_hot_reg);
    assign day_ok = (|ram_rdata[STAR_LSB +: STAR_W]) ? (dom_ok && dow_ok)
                                                      : (dom_ok || dow_ok);
    assign entry_hit = (|(ram_rdata[MIN_LSB  +: MINUTE_W] & min_hot_reg))
                    && (|(ram_rdata[HOUR_LSB +: HOUR_W]   & hour_hot_reg))
                    && (|(ram_rdata[MON_LSB  +: MONTH_W]  & mon_hot_reg))
                    && day_ok;
    assign hit = eval_valid_reg && entry_hit;

    // ------------------------------------------------------------------
    // Sequencer. During a scan the memory read for entry i+1 overlaps the
    // check of entry i. A hit is held back until the next hit or scan end so
    // the last one can be marked; a second hit with the output still occupied
    // stalls the scan and re-reads the entry under check so its data holds.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        scan_ptr_next   = scan_ptr_reg;
        eval_valid_next = eval_valid_reg;
        eval_idx_next   = eval_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        ram_we          = 1'b0;
        ram_raddr       = scan_ptr_reg[IDX_W-1:0];
        stall           = 1'b0;
        push            = 1'b0;
        push_idx        = pend_idx_reg;
        push_found      = 1'b1;
        push_last       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                begin
                    if (cmd.command == CMD_TICK)
                    begin
                        state_next      = ST_SCAN;
                        scan_ptr_next   = '0;
                        eval_valid_next = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    else if (idx_ok && sel_ok)
                    begin
                        state_next = ST_WRD;
                    end
                end
            end

            ST_WRD:
            begin
                // Fetch the entry so the other fields survive the write
                ram_raddr  = wr_addr_reg;
                state_next = ST_WWR;
            end

            ST_WWR:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                stall = hit && pend_valid_reg && !out_free;
                if (stall)
                begin
                    ram_raddr = eval_idx_reg;
                end
                else
                begin
                    if (hit)
                    begin
                        // Release the previous hit, it is not the last one
                        push            = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_idx_next   = eval_idx_reg;
                    end
                    eval_valid_next = (scan_ptr_reg < limit_reg);
                    eval_idx_next   = scan_ptr_reg[IDX_W-1:0];
                    if (scan_ptr_reg < limit_reg)
                    begin
                        scan_ptr_next = scan_ptr_reg + CNT_W'(1);
                    end
                    // Scan done: send the held hit, or a no-match result
                    if (!eval_valid_reg && (scan_ptr_reg == limit_reg) && out_free)
                    begin
                        push            = 1'b1;
                        push_idx        = pend_valid_reg ? pend_idx_reg : '0;
                        push_found      = pend_valid_reg;
                        push_last       = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign push_idx_ext = {5'b0, push_idx};

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            scan_ptr_reg    <= '0;
            eval_valid_reg  <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_ptr_reg   <= scan_ptr_next;
            eval_valid_reg <= eval_valid_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_write)
            begin
                entry_count_reg <= cfg_data;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= eval_idx_next;
        pend_idx_reg <= pend_idx_next;
        if (push)
        begin
            out_index_reg <= push_idx_ext[RES_IDX_W-1:0];
            out_found_reg <= push_found;
            out_last_reg  <= push_last;
        end
        if (cmd_xfer)
        begin
            wr_addr_reg  <= cmd_idx_ext[IDX_W-1:0];
            wr_sel_reg   <= cmd.mask_select;
            wr_val_reg   <= cmd.mask_value;
            limit_reg    <= limit_calc;
            min_hot_reg  <= (cmd.minute < 6'd60) ? (MINUTE_W'(1) << cmd.minute) : '0;
            hour_hot_reg <= (cmd.hour < 5'd24) ? (HOUR_W'(1) << cmd.hour) : '0;
            dom_hot_reg  <= (cmd.day_of_month != 5'd0)
                            ? (DOM_W'(1) << (cmd.day_of_month - 5'd1)) : '0;
            mon_hot_reg  <= ((cmd.month != 4'd0) && (cmd.month < 4'd13))
                            ? (MONTH_W'(1) << (cmd.month - 4'd1)) : '0;
            dow_hot_reg  <= (cmd.day_of_week < 3'd7)
                            ? (WEEKDAY_W'(1) << cmd.day_of_week) : '0;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.matched_index = out_index_reg;
    assign res.found         = out_found_reg;
    assign res.last          = out_last_reg;

`ifndef SYNTHESIS
    // No entry check may be in flight while a new command can be taken
    a_idle_no_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !eval_valid_reg)
        else $error("entry check pending while idle");

    // A result without a match always closes its tick
    a_nomatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.found) |-> res.last)
        else $error("no-match result not marked last");

    // The scan pointer never runs past the scan length
    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_ptr_reg <= limit_reg))
        else $error("scan pointer beyond limit");

    // A stalled check keeps its entry for the next cycle
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && stall) |=> (eval_valid_reg && $stable(eval_idx_reg)))
        else $error("stalled entry check lost");

    // Read of an entry is always followed by its write back
    a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRD) |=> (state_reg == ST_WWR))
        else $error("entry write back skipped");
`endif

endmodule

`default_nettype wire
